// ----- sv/sqcm_pkg.sv -----
package sqcm_pkg;

  // Field and datapath widths.
  localparam int unsigned WordW        = 32;
  localparam int unsigned TimeW        = 63;
  localparam int unsigned StampW       = 64;
  localparam int unsigned ProdW        = 2 * WordW;
  localparam int unsigned RootW        = ProdW / 2;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CountBitsDef = 16;

  // Register reset values.
  localparam logic [WordW-1:0] ThrReset  = 32'd65536;
  localparam logic [WordW-1:0] BaseReset = 32'd100000000;

  // Schedule codes: all ones means that no mark is scheduled.
  localparam logic [StampW-1:0] NoneSched = {StampW{1'b1}};
  localparam logic [StampW-1:0] SatSched  = NoneSched - 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 1'b0,
    CfgBase      = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StDue,
    StStart,
    StDiv,
    StSqrt,
    StAdd,
    StDone
  } sqcm_state_e;

endpackage

// ----- sv/sqcm_div.sv -----
module sqcm_div #(
  parameter int unsigned CountBits = sqcm_pkg::CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sqcm_pkg::ProdW-1:0] dividend_i,
  input  logic [CountBits-1:0]       divisor_i,
  output logic                       done_o,
  output logic [sqcm_pkg::ProdW-1:0] quot_o
);
  import sqcm_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW);

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // at the top while quotient bits shift in at the bottom of the same register.
  logic [ProdW-1:0]     dq_q, dq_d;
  logic [CountBits-1:0] rem_q, rem_d;
  logic [CountBits-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CountBits:0]   trial;
  logic [CountBits:0]   diff;

  always_comb begin
    trial  = {rem_q, dq_q[ProdW-1]};
    diff   = trial - {1'b0, dvs_q};
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(ProdW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // A clear top bit of the difference means the trial did not borrow.
      if (!diff[CountBits]) begin
        rem_d = diff[CountBits-1:0];
        dq_d  = {dq_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = trial[CountBits-1:0];
        dq_d  = {dq_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ----- sv/sqcm_isqrt.sv -----
module sqcm_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sqcm_pkg::ProdW-1:0] radicand_i,
  output logic                       done_o,
  output logic [sqcm_pkg::RootW-1:0] root_o
);
  import sqcm_pkg::*;

  localparam int unsigned CntW = $clog2(RootW);

  // Digit-by-digit square root: two radicand bits enter per cycle and one
  // root bit leaves. The partial remainder never exceeds twice the root.
  logic [ProdW-1:0] rad_q, rad_d;
  logic [RootW-1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RootW+1:0] trial_rem;
  logic [RootW+1:0] trial_sub;
  logic [RootW+1:0] diff;

  always_comb begin
    trial_rem = {rem_q, rad_q[ProdW-1 -: 2]};
    trial_sub = {root_q, 2'b01};
    diff      = trial_rem - trial_sub;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[ProdW-3:0], 2'b00};
      if (trial_rem >= trial_sub) begin
        rem_d  = diff[RootW-1:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = trial_rem[RootW-1:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- sv/send_queue_congestion_marker.sv -----
// Send queue congestion marker. Each request on the input channel describes
// one outgoing packet (queue length, capacity, time) and yields exactly one
// response with the congestion mark decision and the congested flag. The
// effective threshold is the configured threshold, lowered to half the queue
// capacity when the capacity is known. While the queue is above it, a packet
// is marked when the scheduled mark time has arrived or one base interval has
// passed since the previous mark, and every mark pushes the schedule forward
// by floor(base / sqrt(count)), computed exactly. For a marked request the
// interval is found by a bit-serial divider that forms floor(base^2 / count),
// followed by a bit-serial square root. The block takes one request at a
// time; a finished response waits in the output register while the next
// request is already accepted. Configuration writes are taken at once and
// must only be issued while no request is in flight.
module send_queue_congestion_marker #(
  parameter int unsigned CountBits = sqcm_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sqcm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sqcm_pkg::WordW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         queue_length_known_i,
  input  logic [sqcm_pkg::WordW-1:0]   queue_length_i,
  input  logic                         capacity_known_i,
  input  logic [sqcm_pkg::WordW-1:0]   queue_capacity_i,
  input  logic [sqcm_pkg::TimeW-1:0]   now_ns_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         mark_o,
  output logic                         congested_o
);
  import sqcm_pkg::*;

  sqcm_state_e state_q, state_d;

  // Configuration registers.
  logic [WordW-1:0] thr_q, thr_d;
  logic [WordW-1:0] base_q, base_d;

  // Captured request fields.
  logic             len_known_q, len_known_d;
  logic [WordW-1:0] qlen_q, qlen_d;
  logic             cap_known_q, cap_known_d;
  logic [WordW-1:0] cap_q, cap_d;
  logic [TimeW-1:0] now_q, now_d;

  // Per-request working values.
  logic              cong_q, cong_d;
  logic              mark_q, mark_d;
  logic [StampW-1:0] deadline_q, deadline_d;

  // Marking schedule, kept across requests.
  logic [StampW-1:0]    next_mark_q, next_mark_d;
  logic [StampW-1:0]    last_mark_q, last_mark_d;
  logic                 ever_q, ever_d;
  logic [CountBits-1:0] count_q, count_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic out_mark_q, out_mark_d;
  logic out_cong_q, out_cong_d;

  // Interval datapath.
  logic              div_start;
  logic              div_done;
  logic [ProdW-1:0]  base_sq;
  logic [ProdW-1:0]  quot;
  logic              sqrt_done;
  logic [RootW-1:0]  root;
  logic [WordW-1:0]  cap_half;
  logic [WordW-1:0]  thr_eff;
  logic [StampW-1:0] now_ext;
  logic              due;
  logic [StampW:0]   sched_sum;

  assign base_sq = ProdW'(base_q) * ProdW'(base_q);

  sqcm_div #(
    .CountBits (CountBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_sq),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // The root unit starts in the cycle in which the quotient is complete.
  sqcm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_done),
    .radicand_i (quot),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_comb begin
    cap_half  = {1'b0, cap_q[WordW-1:1]};
    thr_eff   = (cap_known_q && (cap_half < thr_q)) ? cap_half : thr_q;
    now_ext   = {1'b0, now_q};
    // Before the first mark ever, the interval test always passes.
    due       = !ever_q || (now_ext >= next_mark_q) || (now_ext >= deadline_q);
    sched_sum = {1'b0, next_mark_q} + (StampW + 1)'(root);

    state_d     = state_q;
    thr_d       = thr_q;
    base_d      = base_q;
    len_known_d = len_known_q;
    qlen_d      = qlen_q;
    cap_known_d = cap_known_q;
    cap_d       = cap_q;
    now_d       = now_q;
    cong_d      = cong_q;
    mark_d      = mark_q;
    deadline_d  = deadline_q;
    next_mark_d = next_mark_q;
    last_mark_d = last_mark_q;
    ever_d      = ever_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_mark_d  = out_mark_q;
    out_cong_d  = out_cong_q;

    in_ready_o = (state_q == StIdle);
    div_start  = (state_q == StStart);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold: thr_d  = cfg_data_i;
        CfgBase:      base_d = cfg_data_i;
        default:      ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          len_known_d = queue_length_known_i;
          qlen_d      = queue_length_i;
          cap_known_d = capacity_known_i;
          cap_d       = queue_capacity_i;
          now_d       = now_ns_i;
          state_d     = StEval;
        end
      end
      StEval: begin
        // An unknown queue length never counts as congestion.
        cong_d     = len_known_q && (qlen_q > thr_eff);
        deadline_d = last_mark_q + StampW'(base_q);
        state_d    = StDue;
      end
      StDue: begin
        mark_d = 1'b0;
        if (cong_q && due) begin
          mark_d = 1'b1;
          // The first mark of an episode restarts the schedule at the
          // present time.
          if (count_q == '0) begin
            next_mark_d = now_ext;
          end
          if (count_q != '1) begin
            count_d = count_q + 1'b1;
          end
          last_mark_d = now_ext;
          ever_d      = 1'b1;
          state_d     = StStart;
        end else begin
          // Congestion has ended: drop the schedule and the count.
          if (!cong_q && len_known_q && (next_mark_q != NoneSched)) begin
            next_mark_d = NoneSched;
            count_d     = '0;
          end
          state_d = StDone;
        end
      end
      StStart: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if (sqrt_done) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        // The schedule saturates one below the code for none scheduled.
        if (sched_sum > {1'b0, SatSched}) begin
          next_mark_d = SatSched;
        end else begin
          next_mark_d = sched_sum[StampW-1:0];
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mark_d  = mark_q;
          out_cong_d  = cong_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      thr_q       <= ThrReset;
      base_q      <= BaseReset;
      next_mark_q <= NoneSched;
      last_mark_q <= '0;
      ever_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      base_q      <= base_d;
      next_mark_q <= next_mark_d;
      last_mark_q <= last_mark_d;
      ever_q      <= ever_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_known_q <= len_known_d;
    qlen_q      <= qlen_d;
    cap_known_q <= cap_known_d;
    cap_q       <= cap_d;
    now_q       <= now_d;
    cong_q      <= cong_d;
    mark_q      <= mark_d;
    deadline_q  <= deadline_d;
    out_mark_q  <= out_mark_d;
    out_cong_q  <= out_cong_d;
  end

  assign out_valid_o = out_valid_q;
  assign mark_o      = out_mark_q;
  assign congested_o = out_cong_q;

  // The divider only finishes while the controller waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider finished outside its wait state");

  // The root unit only finishes while the controller waits for it.
  a_sqrt_done_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == StSqrt))
    else $error("square root finished outside its wait state");

  // An idle schedule always comes with a cleared mark count.
  a_idle_sched_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_mark_q == NoneSched) |-> (count_q == '0))
    else $error("mark count nonzero with no mark scheduled");

  // A marked response always reports congestion.
  a_mark_congested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mark_o) |-> congested_o)
    else $error("mark without congestion");

endmodule
